>>> design/irc_line_tokenizer_top_assert.svh
// irc_line_tokenizer_top_assert.svh
// assertion macros shared by the tokenizer checker; no dependencies
`ifndef IRC_LINE_TOKENIZER_TOP_ASSERT_SVH
`define IRC_LINE_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define IRC_LT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("irc line tokenizer check failed");

// next-cycle implication, disabled during reset
`define IRC_LT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("irc line tokenizer check failed");

`endif

>>> design/irc_lt_pkg.sv
// irc_lt_pkg.sv
// types and constants of the irc line tokenizer; no dependencies
package irc_lt_pkg;

   localparam int MID_W = 5;

   // characters with a meaning in the line
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // field kind codes
   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_NICK    = 3'd1;
   localparam logic [2:0] KIND_IDENT   = 3'd2;
   localparam logic [2:0] KIND_HOST    = 3'd3;
   localparam logic [2:0] KIND_COMMAND = 3'd4;
   localparam logic [2:0] KIND_MIDDLE  = 3'd5;
   localparam logic [2:0] KIND_TRAIL   = 3'd6;

   typedef enum logic [8:0] {
      PH_START  = 9'b000000001,
      PH_NICK   = 9'b000000010,
      PH_IDENT  = 9'b000000100,
      PH_HOST   = 9'b000001000,
      PH_CMD    = 9'b000010000,
      PH_PSTART = 9'b000100000,
      PH_PARAM  = 9'b001000000,
      PH_LAST   = 9'b010000000,
      PH_TRAIL  = 9'b100000000
   } phase_type;

   typedef struct packed {
      phase_type        phase;
      logic [MID_W-1:0] mid_count;
      logic             in_token;
   } lt_state_type;

   typedef struct packed {
      logic [2:0]       kind;
      logic [MID_W-1:0] index;
      logic             start;
      logic             prefix_open;
   } lt_label_type;

endpackage

>>> design/irc_lt_req_if.sv
// irc_lt_req_if.sv
// input byte channel of the tokenizer; no dependencies
interface irc_lt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       line_last;

   modport source (output valid, output data_byte, output line_last, input ready);
   modport sink (input valid, input data_byte, input line_last, output ready);
endinterface

>>> design/irc_lt_rsp_if.sv
// irc_lt_rsp_if.sv
// labeled byte channel of the tokenizer; no dependencies
interface irc_lt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic [2:0] field_kind;
   logic [4:0] param_index;
   logic       field_start;
   logic       line_end;
   logic       prefix_only;

   modport source (output valid, output byte_out, output field_kind, output param_index,
                   output field_start, output line_end, output prefix_only, input ready);
   modport sink (input valid, input byte_out, input field_kind, input param_index,
                 input field_start, input line_end, input prefix_only, output ready);
endinterface

>>> design/irc_lt_classify.sv
// irc_lt_classify.sv
// phase machine step for one byte: label and next parse state
// depends on irc_lt_pkg
module irc_lt_classify import irc_lt_pkg::*; #(
   parameter int MAX_MIDDLE = 18
) (
   input  logic         active,
   input  logic [7:0]   data_byte,
   input  lt_state_type state_cur,
   output lt_state_type state_nxt,
   output lt_label_type label
);

   localparam logic [MID_W:0] MID_LIMIT = (MID_W+1)'(MAX_MIDDLE);

   phase_type        ph;
   logic             consumed;
   logic [MID_W:0]   mid_inc;

   always_comb begin
      state_nxt   = state_cur;
      label.kind  = KIND_NONE;
      label.index = '0;
      label.start = 1'b0;
      ph          = state_cur.phase;
      consumed    = 1'b0;
      mid_inc     = {1'b0, state_cur.mid_count} + (MID_W+1)'(1);

      if (active) begin
         // line start picks prefix or command
         if (ph == PH_START) begin
            state_nxt.in_token = 1'b0;
            if (data_byte == CH_COLON) begin
               ph       = PH_NICK;
               consumed = 1'b1;
            end else begin
               ph = PH_CMD;
            end
         end
         state_nxt.phase = ph;

         if (!consumed) begin
            case (ph)
               PH_NICK, PH_IDENT, PH_HOST: begin
                  if (data_byte == CH_SPACE) begin
                     state_nxt.phase    = PH_CMD;
                     state_nxt.in_token = 1'b0;
                  end else if (ph == PH_NICK && data_byte == CH_BANG) begin
                     // leading delimiters are skipped
                     if (state_nxt.in_token) begin
                        state_nxt.phase    = PH_IDENT;
                        state_nxt.in_token = 1'b0;
                     end
                  end else if (ph == PH_IDENT && data_byte == CH_AT) begin
                     if (state_nxt.in_token) begin
                        state_nxt.phase    = PH_HOST;
                        state_nxt.in_token = 1'b0;
                     end
                  end else begin
                     label.kind = (ph == PH_NICK) ? KIND_NICK :
                                  (ph == PH_IDENT) ? KIND_IDENT : KIND_HOST;
                     label.start        = !state_nxt.in_token;
                     state_nxt.in_token = 1'b1;
                  end
               end
               PH_CMD: begin
                  if (data_byte == CH_SPACE) begin
                     state_nxt.phase     = PH_PSTART;
                     state_nxt.mid_count = '0;
                     state_nxt.in_token  = 1'b0;
                  end else begin
                     label.kind         = KIND_COMMAND;
                     label.start        = !state_nxt.in_token;
                     state_nxt.in_token = 1'b1;
                  end
               end
               PH_PSTART: begin
                  if (data_byte == CH_COLON) begin
                     state_nxt.phase    = PH_TRAIL;
                     state_nxt.in_token = 1'b0;
                  end else begin
                     label.index         = state_cur.mid_count;
                     state_nxt.mid_count = mid_inc[MID_W-1:0];
                     // last middle parameter swallows the rest of the line
                     if (mid_inc >= MID_LIMIT) begin
                        state_nxt.phase = PH_LAST;
                        label.kind      = KIND_MIDDLE;
                        label.start     = 1'b1;
                     end else if (data_byte != CH_SPACE) begin
                        state_nxt.phase = PH_PARAM;
                        label.kind      = KIND_MIDDLE;
                        label.start     = 1'b1;
                     end
                  end
               end
               PH_PARAM: begin
                  label.index = state_cur.mid_count - MID_W'(1);
                  if (data_byte == CH_SPACE) begin
                     state_nxt.phase = PH_PSTART;
                  end else begin
                     label.kind = KIND_MIDDLE;
                  end
               end
               PH_LAST: begin
                  label.index = state_cur.mid_count - MID_W'(1);
                  label.kind  = KIND_MIDDLE;
               end
               PH_TRAIL: begin
                  label.kind         = KIND_TRAIL;
                  label.start        = !state_nxt.in_token;
                  state_nxt.in_token = 1'b1;
               end
               default: begin
                  label.kind = KIND_NONE;
               end
            endcase
         end
      end

      // still inside the prefix after this byte
      label.prefix_open = (state_nxt.phase == PH_NICK) || (state_nxt.phase == PH_IDENT) ||
                          (state_nxt.phase == PH_HOST);
   end

endmodule

>>> design/irc_line_tokenizer_top.sv
// channel   dir  transfer        payload
// req_ch    in   valid & ready   data_byte, line_last
// rsp_ch    out  valid & ready   byte_out, field_kind, param_index, field_start,
//                                line_end, prefix_only
//
// one byte per cycle; each byte is labeled combinationally from the phase
// registers and lands in the result register in the cycle after its transfer.
// the result register frees in the cycle it is taken, so req_ch.ready stays
// high while rsp_ch drains; a stalled rsp_ch holds req_ch off.
// synchronous reset returns the parser to line start with no result pending.
// depends on irc_lt_pkg, irc_lt_req_if, irc_lt_rsp_if, irc_lt_classify
module irc_line_tokenizer_top import irc_lt_pkg::*; #(
   parameter int LINE_LIMIT = 512,
   parameter int MAX_MIDDLE = 18
) (
   input logic        clock,
   input logic        reset,
   irc_lt_req_if.sink  req_ch,
   irc_lt_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(LINE_LIMIT + 1);
   localparam logic [CNT_W-1:0] LIMIT_VAL = CNT_W'(LINE_LIMIT);
   localparam lt_state_type STATE_RESET = '{phase: PH_START, mid_count: '0, in_token: 1'b0};

   lt_state_type     state_ff, state_in, state_step;
   lt_label_type     label;
   logic [CNT_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic             seen_zero_ff, seen_zero_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       byte_out_ff;
   logic [2:0]       kind_ff;
   logic [MID_W-1:0] index_ff;
   logic             start_ff, line_end_ff, prefix_only_ff;
   logic             xfer, dropped, active;

   // input side
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign xfer         = req_ch.valid && req_ch.ready;
   assign dropped      = seen_zero_ff || (byte_cnt_ff >= LIMIT_VAL);
   assign active       = !dropped && (req_ch.data_byte != CH_NUL);

   irc_lt_classify #(.MAX_MIDDLE(MAX_MIDDLE)) u_classify (
      .active    (active),
      .data_byte (req_ch.data_byte),
      .state_cur (state_ff),
      .state_nxt (state_step),
      .label     (label)
   );

   // parse state update; the last byte returns everything to line start
   always_comb begin
      state_in     = state_ff;
      byte_cnt_in  = byte_cnt_ff;
      seen_zero_in = seen_zero_ff;
      if (xfer) begin
         if (req_ch.line_last) begin
            state_in     = STATE_RESET;
            byte_cnt_in  = '0;
            seen_zero_in = 1'b0;
         end else begin
            state_in     = state_step;
            byte_cnt_in  = byte_cnt_ff + CNT_W'(active);
            seen_zero_in = seen_zero_ff || (!dropped && req_ch.data_byte == CH_NUL);
         end
      end
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         byte_cnt_ff  <= '0;
         seen_zero_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         byte_cnt_ff  <= byte_cnt_in;
         seen_zero_ff <= seen_zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (xfer) begin
         byte_out_ff    <= req_ch.data_byte;
         kind_ff        <= label.kind;
         index_ff       <= label.index;
         start_ff       <= label.start;
         line_end_ff    <= req_ch.line_last;
         prefix_only_ff <= req_ch.line_last && label.prefix_open;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.byte_out    = byte_out_ff;
   assign rsp_ch.field_kind  = kind_ff;
   assign rsp_ch.param_index = index_ff;
   assign rsp_ch.field_start = start_ff;
   assign rsp_ch.line_end    = line_end_ff;
   assign rsp_ch.prefix_only = prefix_only_ff;

endmodule

>>> design/irc_lt_checker.sv
// irc_lt_checker.sv
// port-level checks of the tokenizer, bound to the top level
// depends on irc_lt_pkg, irc_line_tokenizer_top_assert.svh
`include "irc_line_tokenizer_top_assert.svh"

module irc_lt_checker import irc_lt_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_data_byte,
   input logic       req_line_last,
   input logic       rsp_valid,
   input logic [7:0] rsp_byte_out,
   input logic [2:0] rsp_field_kind,
   input logic       rsp_field_start,
   input logic       rsp_line_end,
   input logic       rsp_prefix_only
);

   logic req_xfer;
   assign req_xfer = req_valid && req_ready;

   // an accepted byte shows as a result in the next cycle
   `IRC_LT_ASSERT_NEXT(a_result_follows, clock, reset, req_xfer, rsp_valid)
   // the byte passes through unchanged
   `IRC_LT_ASSERT_NEXT(a_byte_passes, clock, reset, req_xfer, rsp_byte_out == $past(req_data_byte))
   // line end mirrors the last-byte flag
   `IRC_LT_ASSERT_NEXT(a_line_end_copy, clock, reset, req_xfer, rsp_line_end == $past(req_line_last))
   // prefix-only flag appears only on the last byte of a line
   `IRC_LT_ASSERT_NOW(a_prefix_only_last, clock, reset, rsp_valid && rsp_prefix_only, rsp_line_end)
   // separators never open a field
   `IRC_LT_ASSERT_NOW(a_sep_no_start, clock, reset, rsp_valid && rsp_field_kind == KIND_NONE, !rsp_field_start)

endmodule

bind irc_line_tokenizer_top irc_lt_checker u_irc_lt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_data_byte   (req_ch.data_byte),
   .req_line_last   (req_ch.line_last),
   .rsp_valid       (rsp_ch.valid),
   .rsp_byte_out    (rsp_ch.byte_out),
   .rsp_field_kind  (rsp_ch.field_kind),
   .rsp_field_start (rsp_ch.field_start),
   .rsp_line_end    (rsp_ch.line_end),
   .rsp_prefix_only (rsp_ch.prefix_only)
);

>>> sim/tb_top.sv
// tb_top.sv
// self-checking bench for irc_line_tokenizer_top: labels every byte with its own model
// depends on irc_lt_pkg, irc_lt_req_if, irc_lt_rsp_if and the tokenizer rtl
module tb_top import irc_lt_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_LIMIT   = 512;
   localparam int MAX_MIDDLE   = 18;
   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT  = 400_000;
   localparam int HOLD_AT      = 500;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_LIMIT  = 2000;
   localparam int MAX_PRINTS   = 40;

   // one labeled byte as it leaves the block
   typedef struct packed {
      logic [7:0] byte_val;
      logic [2:0] kind;
      logic [4:0] index;
      logic       start;
      logic       line_end;
      logic       prefix_only;
   } label_rec_t;

   // one row of the directed table
   typedef struct {
      logic [7:0] ch;
      logic       last;
      bit         typed;
      label_rec_t want;
   } dir_row_t;

   logic clock = 1'b0;
   logic reset;

   irc_lt_req_if req_if();
   irc_lt_rsp_if rsp_if();

   irc_line_tokenizer_top #(
      .LINE_LIMIT(LINE_LIMIT),
      .MAX_MIDDLE(MAX_MIDDLE)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // tokenizer model state
   phase_type tok_phase;
   int        tok_mid_count;
   int        tok_byte_count;
   bit        tok_zero_seen;
   bit        tok_in_token;

   label_rec_t pending_labels[$];
   dir_row_t   dir_rows[$];
   logic [7:0] line_buf[$];

   int  fail_count;
   int  results_checked;
   int  bytes_accepted;
   int  lines_sent;
   int  absorb_count;
   int  ponly_count;
   int  kind_count[0:7];
   int  cycle_count;
   bit  source_calm;
   bit  sink_calm;
   bit  hold_done;

   function automatic void clear_tokenizer();
      tok_phase      = PH_START;
      tok_mid_count  = 0;
      tok_byte_count = 0;
      tok_zero_seen  = 1'b0;
      tok_in_token   = 1'b0;
   endfunction

   // label one byte and advance the parser state
   function automatic label_rec_t label_next_byte(input logic [7:0] ch, input logic last);
      label_rec_t r;
      bit         consumed;
      r          = '0;
      r.byte_val = ch;
      r.line_end = last;
      consumed   = 1'b0;
      if (tok_zero_seen || tok_byte_count >= LINE_LIMIT) begin
         // past a zero byte or the line limit: dropped
      end else if (ch == CH_NUL) begin
         tok_zero_seen = 1'b1;
      end else begin
         tok_byte_count++;
         if (tok_phase == PH_START) begin
            tok_in_token = 1'b0;
            if (ch == CH_COLON) begin
               tok_phase = PH_NICK;
               consumed  = 1'b1;
            end else begin
               tok_phase = PH_CMD;
            end
         end
         if (!consumed) begin
            case (tok_phase)
               PH_NICK, PH_IDENT, PH_HOST: begin
                  if (ch == CH_SPACE) begin
                     tok_phase    = PH_CMD;
                     tok_in_token = 1'b0;
                  end else if (tok_phase == PH_NICK && ch == CH_BANG) begin
                     // leading bangs are skipped, a later one closes the nick
                     if (tok_in_token) begin
                        tok_phase    = PH_IDENT;
                        tok_in_token = 1'b0;
                     end
                  end else if (tok_phase == PH_IDENT && ch == CH_AT) begin
                     if (tok_in_token) begin
                        tok_phase    = PH_HOST;
                        tok_in_token = 1'b0;
                     end
                  end else begin
                     r.kind = (tok_phase == PH_NICK)  ? KIND_NICK :
                              (tok_phase == PH_IDENT) ? KIND_IDENT : KIND_HOST;
                     r.start      = !tok_in_token;
                     tok_in_token = 1'b1;
                  end
               end
               PH_CMD: begin
                  if (ch == CH_SPACE) begin
                     tok_phase     = PH_PSTART;
                     tok_mid_count = 0;
                     tok_in_token  = 1'b0;
                  end else begin
                     r.kind       = KIND_COMMAND;
                     r.start      = !tok_in_token;
                     tok_in_token = 1'b1;
                  end
               end
               PH_PSTART: begin
                  if (ch == CH_COLON) begin
                     tok_phase    = PH_TRAIL;
                     tok_in_token = 1'b0;
                  end else begin
                     r.index = 5'(tok_mid_count);
                     tok_mid_count++;
                     // the last allowed parameter swallows the rest of the line
                     if (tok_mid_count >= MAX_MIDDLE) begin
                        tok_phase = PH_LAST;
                        r.kind    = KIND_MIDDLE;
                        r.start   = 1'b1;
                     end else if (ch != CH_SPACE) begin
                        tok_phase = PH_PARAM;
                        r.kind    = KIND_MIDDLE;
                        r.start   = 1'b1;
                     end
                  end
               end
               PH_PARAM: begin
                  r.index = 5'(tok_mid_count - 1);
                  if (ch == CH_SPACE) tok_phase = PH_PSTART;
                  else r.kind = KIND_MIDDLE;
               end
               PH_LAST: begin
                  r.index = 5'(tok_mid_count - 1);
                  r.kind  = KIND_MIDDLE;
               end
               PH_TRAIL: begin
                  r.kind       = KIND_TRAIL;
                  r.start      = !tok_in_token;
                  tok_in_token = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
      if (last) begin
         r.prefix_only = (tok_phase == PH_NICK) || (tok_phase == PH_IDENT) ||
                         (tok_phase == PH_HOST);
         clear_tokenizer();
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [9:0] got,
                                  input logic [9:0] want);
      fail_count++;
      if (fail_count <= MAX_PRINTS)
         $display("%0t: result %0d: %s is %0h, expected %0h",
                  $realtime, results_checked, what, got, want);
   endtask

   function automatic int draw_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, 15);
   endfunction

   // directed table rows, model-predicted or with the label typed in
   function automatic void add_row(input logic [7:0] ch, input logic last);
      dir_row_t row;
      row.ch    = ch;
      row.last  = last;
      row.typed = 1'b0;
      row.want  = '0;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_typed(input logic [7:0] ch, input logic last,
                                     input logic [2:0] kind, input logic [4:0] index,
                                     input logic start, input logic ponly);
      dir_row_t row;
      row.ch                = ch;
      row.last              = last;
      row.typed             = 1'b1;
      row.want.byte_val     = ch;
      row.want.kind         = kind;
      row.want.index        = index;
      row.want.start        = start;
      row.want.line_end     = last;
      row.want.prefix_only  = ponly;
      dir_rows.push_back(row);
   endfunction

   // offer one byte, wait for its transfer, then queue its expected label
   task automatic send_byte(input logic [7:0] ch, input logic last, input bit typed,
                            input label_rec_t typed_label);
      int         gap;
      label_rec_t want;
      gap = draw_gap(source_calm);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= ch;
      req_if.line_last <= last;
      do @(posedge clock); while (!req_if.ready);
      want = label_next_byte(ch, last);
      pending_labels.push_back(typed ? typed_label : want);
      bytes_accepted++;
   endtask

   task automatic wait_for_drain();
      int waited;
      waited = 0;
      while (pending_labels.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // line content generators
   function automatic logic [7:0] word_char();
      if ($urandom_range(0, 9) < 8) return 8'("a" + $urandom_range(0, 25));
      return 8'($urandom_range(33, 255));
   endfunction

   function automatic void add_word(input int min_len, input int max_len);
      repeat ($urandom_range(min_len, max_len)) line_buf.push_back(word_char());
   endfunction

   function automatic void build_wellformed();
      int n_mid;
      bit all_empty;
      // optional prefix, sometimes with leading delimiters or missing parts
      if ($urandom_range(0, 2) != 0) begin
         line_buf.push_back(CH_COLON);
         repeat ($urandom_range(0, 2)) line_buf.push_back(CH_BANG);
         add_word(0, 6);
         if ($urandom_range(0, 3) != 0) begin
            line_buf.push_back(CH_BANG);
            repeat ($urandom_range(0, 2)) line_buf.push_back(CH_AT);
            add_word(0, 5);
            if ($urandom_range(0, 3) != 0) begin
               line_buf.push_back(CH_AT);
               add_word(0, 8);
            end
         end
         line_buf.push_back(CH_SPACE);
      end
      if ($urandom_range(0, 9) != 0) add_word(1, 7);
      // middle parameters, now and then past the absorbing one
      n_mid     = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 4);
      all_empty = ($urandom_range(0, 5) == 0);
      repeat (n_mid) begin
         line_buf.push_back(CH_SPACE);
         if (!all_empty && $urandom_range(0, 4) != 0) add_word(1, 5);
      end
      // trailing parameter with spaces and colons inside
      if ($urandom_range(0, 1) != 0) begin
         line_buf.push_back(CH_SPACE);
         line_buf.push_back(CH_COLON);
         repeat ($urandom_range(0, 12)) begin
            case ($urandom_range(0, 5))
               0:       line_buf.push_back(CH_SPACE);
               1:       line_buf.push_back(CH_COLON);
               default: line_buf.push_back(word_char());
            endcase
         end
      end
   endfunction

   function automatic void build_random_line();
      line_buf.delete();
      case ($urandom_range(0, 9))
         7: begin
            // noise over the whole byte range
            repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
         end
         8: begin
            // prefix cut off before its space
            line_buf.push_back(CH_COLON);
            repeat ($urandom_range(0, 8)) begin
               case ($urandom_range(0, 3))
                  0:       line_buf.push_back(CH_BANG);
                  1:       line_buf.push_back(CH_AT);
                  default: line_buf.push_back(word_char());
               endcase
            end
         end
         9: begin
            // very short lines of special characters
            repeat ($urandom_range(1, 3)) begin
               case ($urandom_range(0, 5))
                  0:       line_buf.push_back(CH_COLON);
                  1:       line_buf.push_back(CH_SPACE);
                  2:       line_buf.push_back(CH_BANG);
                  3:       line_buf.push_back(CH_AT);
                  4:       line_buf.push_back(8'hFF);
                  default: line_buf.push_back(CH_NUL);
               endcase
            end
         end
         6: begin
            // well-formed line broken by a zero byte
            build_wellformed();
            add_word(1, 3);
            line_buf[$urandom_range(0, line_buf.size() - 1)] = CH_NUL;
         end
         default: begin
            build_wellformed();
         end
      endcase
      if (line_buf.size() == 0) line_buf.push_back(word_char());
   endfunction

   // trailing line that runs past the length limit
   function automatic void build_long_line();
      line_buf.delete();
      line_buf.push_back("X");
      line_buf.push_back(CH_SPACE);
      line_buf.push_back(CH_COLON);
      while (line_buf.size() < LINE_LIMIT)
         line_buf.push_back(($urandom_range(0, 7) == 0) ? CH_SPACE : word_char());
      repeat ($urandom_range(1, 40)) line_buf.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic send_line();
      for (int i = 0; i < line_buf.size(); i++)
         send_byte(line_buf[i], i == line_buf.size() - 1, 1'b0, '0);
      lines_sent++;
   endtask

   // result side: random stalls, one long hold, field by field compare
   initial begin : result_sink
      int         gap;
      label_rec_t want;
      rsp_if.ready <= 1'b0;
      sink_calm = 1'b0;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (results_checked == HOLD_AT && !hold_done) begin
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = draw_gap(sink_calm);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         // transfer seen at this edge
         if (pending_labels.size() == 0) begin
            report_mismatch("result with nothing pending", {2'b0, rsp_if.byte_out}, '0);
         end else begin
            want = pending_labels.pop_front();
            if (rsp_if.byte_out !== want.byte_val)
               report_mismatch("byte_out", {2'b0, rsp_if.byte_out}, {2'b0, want.byte_val});
            if (rsp_if.field_kind !== want.kind)
               report_mismatch("field_kind", {7'b0, rsp_if.field_kind}, {7'b0, want.kind});
            if (rsp_if.param_index !== want.index)
               report_mismatch("param_index", {5'b0, rsp_if.param_index}, {5'b0, want.index});
            if (rsp_if.field_start !== want.start)
               report_mismatch("field_start", {9'b0, rsp_if.field_start}, {9'b0, want.start});
            if (rsp_if.line_end !== want.line_end)
               report_mismatch("line_end", {9'b0, rsp_if.line_end}, {9'b0, want.line_end});
            if (rsp_if.prefix_only !== want.prefix_only)
               report_mismatch("prefix_only", {9'b0, rsp_if.prefix_only},
                               {9'b0, want.prefix_only});
         end
         results_checked++;
         kind_count[rsp_if.field_kind]++;
         if (rsp_if.field_kind == KIND_MIDDLE && rsp_if.param_index == 5'(MAX_MIDDLE - 1))
            absorb_count++;
         if (rsp_if.prefix_only === 1'b1) ponly_count++;
         if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
      end
   end

   // run limit
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout: run still going after %0d cycles", CYCLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // byte source: reset, directed table, random lines, drain and verdict
   initial begin : byte_source
      int  random_bytes;
      bit  long_done;
      bit  pause_done;
      fail_count      = 0;
      results_checked = 0;
      bytes_accepted  = 0;
      lines_sent      = 0;
      absorb_count    = 0;
      ponly_count     = 0;
      foreach (kind_count[k]) kind_count[k] = 0;
      source_calm = 1'b0;
      clear_tokenizer();
      req_if.valid     <= 1'b0;
      req_if.data_byte <= '0;
      req_if.line_last <= 1'b0;
      reset            <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full prefix with skipped delimiters, command, empty middle, trailing
      add_typed(":", 1'b0, KIND_NONE, 5'd0, 1'b0, 1'b0);
      add_row("!", 1'b0);
      add_row("n", 1'b0);
      add_row("!", 1'b0);
      add_row("@", 1'b0);
      add_row("i", 1'b0);
      add_row("@", 1'b0);
      add_row("h", 1'b0);
      add_row(" ", 1'b0);
      add_row("C", 1'b0);
      add_row(" ", 1'b0);
      add_row("p", 1'b0);
      add_row(" ", 1'b0);
      add_row(" ", 1'b0);
      add_row(":", 1'b0);
      add_row("t", 1'b1);
      // prefix with no space, top byte value
      add_row(":", 1'b0);
      add_typed(8'hFF, 1'b1, KIND_NICK, 5'd0, 1'b1, 1'b1);
      // empty command and empty trailing parameter
      add_row(" ", 1'b0);
      add_row(":", 1'b1);
      // zero byte drops the rest of the line
      add_typed("A", 1'b0, KIND_COMMAND, 5'd0, 1'b1, 1'b0);
      add_typed(CH_NUL, 1'b0, KIND_NONE, 5'd0, 1'b0, 1'b0);
      add_typed("B", 1'b1, KIND_NONE, 5'd0, 1'b0, 1'b0);
      foreach (dir_rows[i]) begin
         send_byte(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
         if (dir_rows[i].last) lines_sent++;
      end

      // let everything drain before random traffic starts
      req_if.valid <= 1'b0;
      wait_for_drain();

      random_bytes = 0;
      long_done    = 1'b0;
      pause_done   = 1'b0;
      while (random_bytes < RANDOM_ITEMS) begin
         if (!long_done && random_bytes >= 600) begin
            long_done = 1'b1;
            build_long_line();
         end else begin
            build_random_line();
         end
         source_calm = ($urandom_range(0, 3) == 0);
         random_bytes += line_buf.size();
         send_line();
         if (!pause_done && random_bytes >= 900) begin
            pause_done = 1'b1;
            req_if.valid <= 1'b0;
            wait_for_drain();
         end
      end
      req_if.valid <= 1'b0;

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (pending_labels.size() != 0)
         report_mismatch("labels never delivered", 10'(pending_labels.size()), '0);

      $display("covered %0d lines, %0d bytes, %0d results checked, %0d mismatches",
               lines_sent, bytes_accepted, results_checked, fail_count);
      $display("labels: nick %0d ident %0d host %0d command %0d middle %0d trailing %0d,"
               , kind_count[1], kind_count[2], kind_count[3], kind_count[4],
               kind_count[5], kind_count[6]);
      $display("absorbing-parameter bytes %0d, open-prefix line ends %0d",
               absorb_count, ponly_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> irc_line_tokenizer_top.f
+incdir+design
design/irc_lt_pkg.sv
design/irc_lt_req_if.sv
design/irc_lt_rsp_if.sv
design/irc_lt_classify.sv
design/irc_line_tokenizer_top.sv
design/irc_lt_checker.sv
sim/tb_top.sv
